FILE: design/assert_macros.svh
// Assertion macros shared by the timer event queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: design/tepq_pkg.sv
// Types, constants and helper functions for the timer event queue.
`default_nettype none
package tepq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int FUNC_W      = 1;
   localparam int ID_W        = 8;
   localparam int TICK_W      = 32;
   localparam int ENTRY_W     = 5;
   localparam int STATUS_W    = 2;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   typedef struct packed {
      logic              used;
      logic [ID_W-1:0]   event_id;
      logic [TICK_W-1:0] due_tick;
   } slot_type;

   localparam slot_type EMPTY_SLOT = '0;

   // Operation broadcast to every cell of the row.
   typedef struct packed {
      logic              write;
      logic              insert;
      logic [ID_W-1:0]   event_id;
      logic [TICK_W-1:0] due_tick;
   } op_type;

   // Flags that ripple from each cell to its right-hand neighbour.
   typedef struct packed {
      logic removed;
      logic placed;
   } link_type;

   // True when tick a falls strictly before tick b on the wrapping time line.
   function automatic logic due_before(input logic [TICK_W-1:0] a,
                                       input logic [TICK_W-1:0] b);
      logic [TICK_W-1:0] diff;
      diff = a - b;
      return diff[TICK_W-1];
   endfunction

endpackage
`default_nettype wire

FILE: design/tepq_channels.sv
// Handshake interfaces for the request and response channels of the queue.
`default_nettype none
interface tepq_req_if;
   logic                          valid;
   logic                          ready;
   logic [tepq_pkg::FUNC_W-1:0]   func;
   logic [tepq_pkg::ID_W-1:0]     event_id;
   logic [tepq_pkg::TICK_W-1:0]   due_tick;

   modport source (output valid, func, event_id, due_tick, input ready);
   modport sink (input valid, func, event_id, due_tick, output ready);
endinterface

interface tepq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          head_valid;
   logic [tepq_pkg::ID_W-1:0]     head_id;
   logic [tepq_pkg::TICK_W-1:0]   head_tick;
   logic [tepq_pkg::ENTRY_W-1:0]  entry_count;
   logic [tepq_pkg::STATUS_W-1:0] status;

   modport source (output valid, head_valid, head_id, head_tick, entry_count, status,
                   input ready);
   modport sink (input valid, head_valid, head_id, head_tick, entry_count, status,
                 output ready);
endinterface
`default_nettype wire

FILE: design/tepq_cell.sv
// One slot of the sorted queue row, with its removal and placement logic.
`default_nettype none
module tepq_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  tepq_pkg::op_type        op,
   input  tepq_pkg::slot_type      left_slot,
   input  tepq_pkg::slot_type      right_slot,
   input  tepq_pkg::link_type      link_in,
   output tepq_pkg::slot_type      own_slot,
   output tepq_pkg::slot_type      shifted_slot,
   output tepq_pkg::link_type      link_out
);

   logic                            used_ff;
   logic [tepq_pkg::ID_W-1:0]       event_id_ff;
   logic [tepq_pkg::TICK_W-1:0]     due_tick_ff;
   tepq_pkg::slot_type              slot_in;
   logic                            match;
   logic                            later;

   assign own_slot = '{used: used_ff, event_id: event_id_ff, due_tick: due_tick_ff};
   assign match = used_ff && (event_id_ff == op.event_id);
   assign link_out.removed = link_in.removed | match;

   // Once the old entry lies at or to the left, this slot closes the gap.
   assign shifted_slot = link_out.removed ? right_slot : own_slot;

   // An empty slot is where an event goes when nothing queued is due later.
   assign later = !shifted_slot.used ||
                  tepq_pkg::due_before(op.due_tick, shifted_slot.due_tick);
   assign link_out.placed = link_in.placed | later;

   always_comb begin
      priority if (!op.write) begin
         slot_in = own_slot;
      end else if (!op.insert) begin
         slot_in = shifted_slot;
      end else if (link_in.placed) begin
         slot_in = left_slot;
      end else if (later) begin
         slot_in = '{used: 1'b1, event_id: op.event_id, due_tick: op.due_tick};
      end else begin
         slot_in = shifted_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= slot_in.used;
      end
   end

   always_ff @(posedge clock) begin
      event_id_ff <= slot_in.event_id;
      due_tick_ff <= slot_in.due_tick;
   end

endmodule
`default_nettype wire

FILE: design/timed_event_priority_queue_unit.sv
// Timer event queue: a row of sorted slots updated by one insert or remove per transaction.
// The response is registered and appears in the cycle after the request transaction is accepted.
// Throughput: one transaction per cycle while the response side is ready; the row of cells
// settles removal, placement and shifting combinationally through its neighbour-to-neighbour flags.
// Reset clears every slot's used bit, the event count and the response valid; the stored
// identifiers and ticks are not reset.
`default_nettype none
`include "assert_macros.svh"
module timed_event_priority_queue_unit (
   input wire logic      clock,
   input wire logic      reset,
   tepq_req_if.sink      req_chan,
   tepq_rsp_if.source    rsp_chan
);

   localparam int DEPTH = tepq_pkg::QUEUE_DEPTH;

   tepq_pkg::slot_type              own_slot [DEPTH];
   tepq_pkg::slot_type              shifted_slot [DEPTH];
   tepq_pkg::link_type              link [DEPTH+1];
   tepq_pkg::op_type                op;
   logic [DEPTH-1:0]                used_vec;
   logic [tepq_pkg::COUNT_W-1:0]    count_ff;
   logic [tepq_pkg::COUNT_W-1:0]    count_in;
   tepq_pkg::status_type            status_ff;
   tepq_pkg::status_type            status_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            accept;
   logic                            is_insert;
   logic                            found;
   logic                            full;
   logic                            drop;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign is_insert = (req_chan.func == tepq_pkg::FUNC_INSERT);

   assign found = link[DEPTH].removed;
   assign full = own_slot[DEPTH-1].used;
   assign drop = is_insert && !found && full;

   assign op.write = accept && !drop;
   assign op.insert = is_insert;
   assign op.event_id = req_chan.event_id;
   assign op.due_tick = req_chan.due_tick;

   assign link[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      tepq_pkg::slot_type left_slot;
      tepq_pkg::slot_type right_slot;

      if (i == 0) begin : g_first
         assign left_slot = tepq_pkg::EMPTY_SLOT;
      end else begin : g_inner_left
         assign left_slot = shifted_slot[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_slot = tepq_pkg::EMPTY_SLOT;
      end else begin : g_inner_right
         assign right_slot = own_slot[i+1];
      end

      tepq_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .op           (op),
         .left_slot    (left_slot),
         .right_slot   (right_slot),
         .link_in      (link[i]),
         .own_slot     (own_slot[i]),
         .shifted_slot (shifted_slot[i]),
         .link_out     (link[i+1])
      );

      assign used_vec[i] = own_slot[i].used;
   end

   always_comb begin
      count_in = count_ff;
      if (op.write) begin
         count_in = count_ff - tepq_pkg::COUNT_W'(found)
                    + tepq_pkg::COUNT_W'(is_insert);
      end
   end

   always_comb begin
      priority if (is_insert) begin
         status_in = drop ? tepq_pkg::STATUS_FULL : tepq_pkg::STATUS_DONE;
      end else begin
         status_in = found ? tepq_pkg::STATUS_DONE : tepq_pkg::STATUS_MISSING;
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // The queue only changes on an accepted transaction, so the response reads it directly.
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.head_valid  = own_slot[0].used;
   assign rsp_chan.head_id     = own_slot[0].used ? own_slot[0].event_id : '0;
   assign rsp_chan.head_tick   = own_slot[0].used ? own_slot[0].due_tick : '0;
   assign rsp_chan.entry_count = tepq_pkg::ENTRY_W'(count_ff);
   assign rsp_chan.status      = status_ff;

   `ASSERT_NEVER(a_used_contiguous, clock, reset, ((used_vec + DEPTH'(1)) & used_vec) != '0, "used slots are not a prefix of the row")
   `ASSERT_NEVER(a_count_matches, clock, reset, count_ff != $countones(used_vec), "event count disagrees with used slots")
   `ASSERT_CLK(a_accept_gives_rsp, clock, reset, accept |=> rsp_valid_ff, "accepted transaction produced no response")
   `ASSERT_CLK(a_stall_holds_queue, clock, reset, (rsp_valid_ff && !rsp_chan.ready) |=> ($stable(used_vec) && $stable(count_ff)), "queue changed while response stalled")

endmodule
`default_nettype wire
